### sv/ptg_pkg.sv
// Package for the polyphonic tone generator.
// Holds codes, prescaler tables and the controller/datapath command types.
// No dependencies.
`default_nettype none
package ptg_pkg;

  localparam int SLOT_W = 3;
  localparam int LVL_W = 5;
  localparam int PIN_W = 8;
  localparam int FREQ_W = 16;
  localparam int DUR_W = 32;
  localparam int CMP_W = 16;
  localparam int PRE_W = 3;
  localparam int POLY_W = 3;
  localparam int DIVN_W = 48;
  localparam int DIVD_W = 17;

  localparam logic [PIN_W-1:0] FREE_PIN = 8'd255;
  localparam logic [SLOT_W-1:0] EIGHT_BIT_SLOT = 3'd3;
  localparam logic [DUR_W-1:0] INFINITE_TOGGLES = 32'hFFFF_FFFF;
  localparam logic [DUR_W-1:0] TOGGLE_MAX = 32'h7FFF_FFFF;
  localparam logic [CMP_W-1:0] CMP_MAX = 16'hFFFF;
  localparam logic [DIVD_W-1:0] MS_PER_S = 17'd1000;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_STOP = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [PRE_W-1:0] PRE_DIV1 = 3'd0;
  localparam logic [PRE_W-1:0] PRE_DIV64 = 3'd3;
  localparam logic [PRE_W-1:0] PRE_DIV1024 = 3'd6;

  typedef struct packed {
    logic take_simple;
    logic latch;
    logic div_start;
    logic div_sel;
    logic save_q0;
    logic save_tc;
    logic commit;
  } ptg_cmd_t;

  typedef struct packed {
    logic long_start;
    logic div_done;
  } ptg_status_t;

  function automatic logic [3:0] prescale_shift(input logic [PRE_W-1:0] code);
    logic [3:0] sh;
    unique case (code)
      3'd0: sh = 4'd0;
      3'd1: sh = 4'd3;
      3'd2: sh = 4'd5;
      3'd3: sh = 4'd6;
      3'd4: sh = 4'd7;
      3'd5: sh = 4'd8;
      default: sh = 4'd10;
    endcase
    return sh;
  endfunction

  function automatic logic [10:0] prescale_div(input logic [PRE_W-1:0] code);
    return 11'd1 << prescale_shift(code);
  endfunction

  function automatic logic [31:0] fit_value(input logic [31:0] q);
    return (q == 32'd0) ? 32'd0 : q - 32'd1;
  endfunction

endpackage
`default_nettype wire

### sv/polyphonic_tone_generator.sv
// Top level of the polyphonic tone generator.
// Depends on ptg_pkg, ptg_ctrl and ptg_datapath.
//
//   channel | handshake              | payload
//   in      | in_valid_i / in_stall_o | action_i pin_i frequency_i duration_ms_i
//   out     | out_valid_o/out_stall_i | slot_o slot_valid_o compare_out_o
//           |                         | prescale_code_o levels_o running_mask_o
//   cfg     | cfg_we_i                | cfg_data_i
//
// Ticks, stops and starts that find no slot are taken directly in the idle state, without the divider.
// A start that obtains a slot passes once through the 48-bit serial divider
// for the half period and then through a two-step reciprocal multiplication
// for the duration scaling.
// Reset leaves every slot free and quiet; no clearing pass is needed.
// A held result blocks new requests until it is taken.
`default_nettype none
module polyphonic_tone_generator
  import ptg_pkg::*;
#(
  parameter int NUM_CHANNELS = 5,
  parameter int CLOCK_HZ = 16000000
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [POLY_W-1:0] cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        action_i,
  input  wire logic [PIN_W-1:0]  pin_i,
  input  wire logic [FREQ_W-1:0] frequency_i,
  input  wire logic [DUR_W-1:0]  duration_ms_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [SLOT_W-1:0]      slot_o,
  output logic                   slot_valid_o,
  output logic [CMP_W-1:0]       compare_out_o,
  output logic [PRE_W-1:0]       prescale_code_o,
  output logic [LVL_W-1:0]       levels_o,
  output logic [LVL_W-1:0]       running_mask_o
);

  ptg_cmd_t    cmd;
  ptg_status_t status;

  ptg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ptg_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .CLOCK_HZ     (CLOCK_HZ)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .action_i        (action_i),
    .pin_i           (pin_i),
    .frequency_i     (frequency_i),
    .duration_ms_i   (duration_ms_i),
    .slot_o          (slot_o),
    .slot_valid_o    (slot_valid_o),
    .compare_out_o   (compare_out_o),
    .prescale_code_o (prescale_code_o),
    .levels_o        (levels_o),
    .running_mask_o  (running_mask_o)
  );

endmodule
`default_nettype wire

### sv/ptg_divider.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on ptg_pkg for the operand widths.
`default_nettype none
module ptg_divider
  import ptg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIVN_W-1:0] dividend_i,
  input  wire logic [DIVD_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [DIVN_W-1:0]      quotient_o
);

  localparam int CNT_W = $clog2(DIVN_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVN_W - 1);

  logic [DIVN_W-1:0] acc_q;
  logic [DIVD_W-1:0] rem_q, dsr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [DIVD_W:0]   trial;
  logic              fits;

  assign trial = {rem_q, acc_q[DIVN_W-1]};
  assign fits = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[DIVN_W-2:0], fits};
      rem_q <= fits ? DIVD_W'(trial - {1'b0, dsr_q}) : trial[DIVD_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quotient_o = acc_q;

endmodule
`default_nettype wire

### sv/ptg_datapath.sv
// Channel state, slot search, tick and stop logic, start arithmetic and result register.
// Depends on ptg_pkg and ptg_divider.
`default_nettype none
module ptg_datapath
  import ptg_pkg::*;
#(
  parameter int NUM_CHANNELS = 5,
  parameter int CLOCK_HZ = 16000000
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ptg_cmd_t          cmd_i,
  output ptg_status_t            status_o,
  input  wire logic              cfg_we_i,
  input  wire logic [POLY_W-1:0] cfg_data_i,
  input  wire logic [1:0]        action_i,
  input  wire logic [PIN_W-1:0]  pin_i,
  input  wire logic [FREQ_W-1:0] frequency_i,
  input  wire logic [DUR_W-1:0]  duration_ms_i,
  output logic [SLOT_W-1:0]      slot_o,
  output logic                   slot_valid_o,
  output logic [CMP_W-1:0]       compare_out_o,
  output logic [PRE_W-1:0]       prescale_code_o,
  output logic [LVL_W-1:0]       levels_o,
  output logic [LVL_W-1:0]       running_mask_o
);

  localparam int Q_W = $clog2(CLOCK_HZ + 1);
  localparam logic [POLY_W-1:0] NCH = POLY_W'(NUM_CHANNELS);
  localparam logic [38:0] RECIP_125 = 39'd281474976711;
  localparam int RECIP_SH = 45;
  localparam logic [DIVN_W-1:0] PROD_CLAMP = DIVN_W'(MS_PER_S) << 31;

  logic [POLY_W-1:0] poly_q;
  logic [PIN_W-1:0]  pin_q [NUM_CHANNELS];
  logic [DUR_W-1:0]  tog_q [NUM_CHANNELS];
  logic [CMP_W-1:0]  cmp_q [NUM_CHANNELS];
  logic [PRE_W-1:0]  psel_q [NUM_CHANNELS];
  logic [9:0]        pcnt_q [NUM_CHANNELS];
  logic [CMP_W-1:0]  tcnt_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] lvl_q, run_q;

  logic [PIN_W-1:0]  pin_d [NUM_CHANNELS];
  logic [DUR_W-1:0]  tog_d [NUM_CHANNELS];
  logic [9:0]        pcnt_d [NUM_CHANNELS];
  logic [CMP_W-1:0]  tcnt_d [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] lvl_d, run_d;

  logic [PIN_W-1:0]  spin_q;
  logic [FREQ_W-1:0] sfreq_q;
  logic [DUR_W-1:0]  sdur_q;
  logic [SLOT_W-1:0] sslot_q;
  logic [DIVN_W-1:0] prod_q;
  logic [Q_W-1:0]    q0_q;
  logic [CMP_W-1:0]  ocr_q;
  logic [PRE_W-1:0]  code_q;
  logic [DUR_W-1:0]  tc_q;

  logic              found;
  logic [SLOT_W-1:0] found_idx;
  logic              is_stop, is_tick;

  logic              div_go;
  logic              div_done;
  logic [DIVN_W-1:0] div_q;
  logic [DIVN_W-1:0] div_n;
  logic [DIVD_W-1:0] div_d;

  logic              rec_start;
  logic [37:0]       rec_y;
  logic [18:0]       rec_chunk;
  logic [57:0]       rec_part;
  logic [76:0]       rec_acc_q;
  logic [1:0]        rec_step_q;
  logic              rec_done_q;

  logic [31:0]       q0_ext, fit, fit64;
  logic [PRE_W-1:0]  code_c;
  logic [CMP_W-1:0]  ocr_c;

  always_comb begin
    found = 1'b0;
    found_idx = '0;
    if (pin_i != FREE_PIN) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (!found && POLY_W'(i) < poly_q && pin_q[i] == pin_i) begin
          found = 1'b1;
          found_idx = SLOT_W'(i);
        end
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (!found && POLY_W'(i) < poly_q && pin_q[i] == FREE_PIN) begin
          found = 1'b1;
          found_idx = SLOT_W'(i);
        end
      end
    end
  end

  assign is_stop = (action_i == ACT_STOP) ||
                   (action_i == ACT_START && frequency_i == '0);
  assign is_tick = action_i == ACT_TICK;
  assign status_o.long_start = action_i == ACT_START && frequency_i != '0 && found;
  assign status_o.div_done = div_done || rec_done_q;

  always_comb begin
    logic [PRE_W-1:0] sel;
    logic [10:0] dv;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      pin_d[i] = pin_q[i];
      tog_d[i] = tog_q[i];
      pcnt_d[i] = pcnt_q[i];
      tcnt_d[i] = tcnt_q[i];
      lvl_d[i] = lvl_q[i];
      run_d[i] = run_q[i];
      sel = (psel_q[i] > PRE_DIV1024) ? PRE_DIV1024 : psel_q[i];
      dv = prescale_div(sel);
      if (is_stop) begin
        if (pin_i != FREE_PIN && pin_q[i] == pin_i) begin
          pin_d[i] = FREE_PIN;
          run_d[i] = 1'b0;
          lvl_d[i] = 1'b0;
        end
      end else if (is_tick && run_q[i]) begin
        if ({1'b0, pcnt_q[i]} + 11'd1 < dv) begin
          pcnt_d[i] = pcnt_q[i] + 10'd1;
        end else begin
          pcnt_d[i] = '0;
          if (tcnt_q[i] != cmp_q[i]) begin
            tcnt_d[i] = tcnt_q[i] + CMP_W'(1);
          end else begin
            tcnt_d[i] = '0;
            if (tog_q[i] != '0) begin
              lvl_d[i] = ~lvl_q[i];
              if (tog_q[i] != INFINITE_TOGGLES) tog_d[i] = tog_q[i] - DUR_W'(1);
            end else begin
              run_d[i] = 1'b0;
              lvl_d[i] = 1'b0;
            end
          end
        end
      end
    end
  end

  assign div_go = cmd_i.div_start && !cmd_i.div_sel;
  assign div_n = DIVN_W'(CLOCK_HZ);
  assign div_d = {sfreq_q, 1'b0};

  ptg_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // The duration scaling divides by 1000 as a shift by 3 and a reciprocal
  // multiplication for 125, done in two partial products.
  assign rec_start = cmd_i.div_start && cmd_i.div_sel;
  assign rec_y = prod_q[40:3];
  assign rec_chunk = (rec_step_q == 2'd2) ? rec_y[37:19] : rec_y[18:0];
  assign rec_part = 58'(rec_chunk) * 58'(RECIP_125);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_step_q <= '0;
      rec_done_q <= 1'b0;
    end else begin
      rec_done_q <= 1'b0;
      if (rec_start) begin
        rec_step_q <= 2'd1;
      end else if (rec_step_q == 2'd1) begin
        rec_step_q <= 2'd2;
      end else if (rec_step_q == 2'd2) begin
        rec_step_q <= '0;
        rec_done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_step_q == 2'd1) rec_acc_q <= 77'(rec_part);
    else if (rec_step_q == 2'd2) rec_acc_q <= rec_acc_q + (77'(rec_part) << 19);
  end

  assign q0_ext = 32'(q0_q);
  assign fit = fit_value(q0_ext);
  assign fit64 = fit_value(q0_ext >> 6);

  always_comb begin
    logic [31:0] f;
    code_c = PRE_DIV1024;
    if (sslot_q == EIGHT_BIT_SLOT) begin
      for (int k = 6; k >= 0; k--) begin
        if ((q0_ext >> prescale_shift(PRE_W'(k))) <= 32'd256) code_c = PRE_W'(k);
      end
      f = fit_value(q0_ext >> prescale_shift(code_c));
    end else if (fit > 32'(CMP_MAX)) begin
      code_c = PRE_DIV64;
      f = fit64;
    end else begin
      code_c = PRE_DIV1;
      f = fit;
    end
    ocr_c = (f > 32'(CMP_MAX)) ? CMP_MAX : f[CMP_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      spin_q <= pin_i;
      sfreq_q <= frequency_i;
      sdur_q <= duration_ms_i;
      sslot_q <= found_idx;
    end
    if (div_go) begin
      prod_q <= DIVN_W'({sfreq_q, 1'b0}) * DIVN_W'(sdur_q[DUR_W-2:0]);
    end
    if (cmd_i.save_q0) q0_q <= div_q[Q_W-1:0];
    if (cmd_i.save_tc) begin
      ocr_q <= ocr_c;
      code_q <= code_c;
      if (sdur_q[DUR_W-1] || sdur_q == '0) tc_q <= INFINITE_TOGGLES;
      else if (prod_q >= PROD_CLAMP) tc_q <= TOGGLE_MAX;
      else tc_q <= rec_acc_q[RECIP_SH +: DUR_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= POLY_W'(1);
      lvl_q <= '0;
      run_q <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pin_q[i] <= FREE_PIN;
        tog_q[i] <= '0;
        cmp_q[i] <= '0;
        psel_q[i] <= '0;
        pcnt_q[i] <= '0;
        tcnt_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i && cfg_data_i != '0) begin
        poly_q <= (cfg_data_i > NCH) ? NCH : cfg_data_i;
      end
      if (cmd_i.take_simple) begin
        lvl_q <= lvl_d;
        run_q <= run_d;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          pin_q[i] <= pin_d[i];
          tog_q[i] <= tog_d[i];
          pcnt_q[i] <= pcnt_d[i];
          tcnt_q[i] <= tcnt_d[i];
        end
      end else if (cmd_i.commit) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (sslot_q == SLOT_W'(i)) begin
            pin_q[i] <= spin_q;
            tog_q[i] <= tc_q;
            cmp_q[i] <= ocr_q;
            psel_q[i] <= code_q;
            pcnt_q[i] <= '0;
            tcnt_q[i] <= '0;
            run_q[i] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_simple) begin
      slot_o <= '0;
      slot_valid_o <= 1'b0;
      compare_out_o <= '0;
      prescale_code_o <= '0;
      levels_o <= LVL_W'(lvl_d);
      running_mask_o <= LVL_W'(run_d);
    end else if (cmd_i.commit) begin
      slot_o <= sslot_q;
      slot_valid_o <= 1'b1;
      compare_out_o <= ocr_q;
      prescale_code_o <= code_q;
      levels_o <= LVL_W'(lvl_q);
      running_mask_o <= LVL_W'(run_q) | (LVL_W'(1) << sslot_q);
    end
  end

endmodule
`default_nettype wire

### sv/ptg_ctrl.sv
// Controller state machine: request acceptance, divider sequencing, result valid.
// Depends on ptg_pkg.
`default_nettype none
module ptg_ctrl
  import ptg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  input  wire ptg_status_t status_i,
  output ptg_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_D1_GO, S_D1_WAIT, S_D2_GO, S_D2_WAIT, S_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free, accept;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == S_IDLE && out_free);
  assign accept = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.latch = accept && status_i.long_start;
        cmd_o.take_simple = accept && !status_i.long_start;
      end
      S_D1_GO: cmd_o.div_start = 1'b1;
      S_D1_WAIT: cmd_o.save_q0 = status_i.div_done;
      S_D2_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel = 1'b1;
      end
      S_D2_WAIT: cmd_o.save_tc = status_i.div_done;
      S_FINISH: cmd_o.commit = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.take_simple || cmd_o.commit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (cmd_o.latch) state_q <= S_D1_GO;
        S_D1_GO: state_q <= S_D1_WAIT;
        S_D1_WAIT: if (status_i.div_done) state_q <= S_D2_GO;
        S_D2_GO: state_q <= S_D2_WAIT;
        S_D2_WAIT: if (status_i.div_done) state_q <= S_FINISH;
        S_FINISH: if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !(out_valid_q && out_stall_i))
    else $error("result written while the previous one is still held");
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == S_D1_WAIT || state_q == S_D2_WAIT))
    else $error("divider finished outside a wait state");
  a_d1_to_d2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_D1_WAIT && status_i.div_done) |=> state_q == S_D2_GO)
    else $error("second division not started after the first");
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.latch |=> in_stall_o)
    else $error("request accepted during a start computation");

endmodule
`default_nettype wire
